FILE: rtl/core/wcenv_pkg.sv
// Shared types, constants and register codes for the waveform column envelope core.
// Used by every module of the core; depends on nothing.
`default_nettype none
package wcenv_pkg;

    localparam int SAMPLE_BITS  = 16;
    localparam int MAX_COLUMNS  = 4096;
    localparam int MAX_CHANNELS = 2;

    localparam int SUM_W   = 34;
    localparam int FRAME_W = 25;
    localparam int START_W = 24;
    localparam int FPC_W   = 16;
    localparam int HALF_W  = 11;
    localparam int CCNT_W  = 13;
    localparam int CLAMP_W = 17;
    localparam int COL_W   = 13;
    localparam int OUT_W   = 12;
    localparam int CH_W    = 2;
    localparam int MODE_W  = 2;
    localparam int CIDX_W  = 3;
    localparam int CDAT_W  = 25;

    localparam logic [FRAME_W-1:0] FRAME_MAX = {FRAME_W{1'b1}};
    localparam logic [FPC_W-1:0]   FIC_MAX   = {FPC_W{1'b1}};
    localparam logic [OUT_W-1:0]   HEIGHT_MAX = {OUT_W{1'b1}};

    // 10*log10(2) in Q16, and the decibel span 45 in Q32
    localparam int DBK_W  = 18;
    localparam int FULL_W = 38;
    localparam logic [DBK_W-1:0]  DB_K    = 18'd197283;
    localparam logic [FULL_W-1:0] DB_FULL = 38'd193273528320;
    localparam logic [5:0]        DB_RANGE = 6'd45;

    // render modes
    localparam logic [MODE_W-1:0] MODE_LIN   = 2'd0;
    localparam logic [MODE_W-1:0] MODE_DB    = 2'd1;
    localparam logic [MODE_W-1:0] MODE_QUICK = 2'd2;
    localparam logic [MODE_W-1:0] MODE_RSV   = 2'd3;

    // register indexes
    localparam logic [CIDX_W-1:0] REG_CHANNELS = 3'd0;
    localparam logic [CIDX_W-1:0] REG_FPC      = 3'd1;
    localparam logic [CIDX_W-1:0] REG_HALF     = 3'd2;
    localparam logic [CIDX_W-1:0] REG_COLS     = 3'd3;
    localparam logic [CIDX_W-1:0] REG_MODE     = 3'd4;
    localparam logic [CIDX_W-1:0] REG_START    = 3'd5;
    localparam logic [CIDX_W-1:0] REG_END      = 3'd6;

    // configuration after range fixing
    typedef struct packed {
        logic [CH_W-1:0]    ch;
        logic [FPC_W-1:0]   fpc;
        logic [HALF_W-1:0]  half;
        logic [CLAMP_W-1:0] cols;
        logic [MODE_W-1:0]  mode;
        logic [START_W-1:0] start;
        logic [FRAME_W-1:0] endf;
    } t_cfg;

    // one closed column waiting for its height
    typedef struct packed {
        logic [SUM_W-1:0] sum;
        logic [OUT_W-1:0] num;
        logic             fin;
    } t_col;

endpackage
`default_nettype wire

FILE: rtl/core/wcenv_front.sv
// Front end: frame counting, window test, magnitude accumulation, column close.
// Depends on wcenv_pkg.
`default_nettype none
module wcenv_front #(
    parameter int SAMPLE_BITS = wcenv_pkg::SAMPLE_BITS
) (
    input  wire                           i_clk,
    input  wire                           i_rst_n,
    input  wire                           i_valid,
    output logic                          o_ready,
    input  wire  signed [SAMPLE_BITS-1:0] i_sample_first,
    input  wire  signed [SAMPLE_BITS-1:0] i_sample_second,
    input  wire  wcenv_pkg::t_cfg         i_cfg,
    input  wire                           i_space,
    output logic                          o_push,
    output wcenv_pkg::t_col               o_col
);
    localparam int MAG_W = SAMPLE_BITS + 1;

    logic [wcenv_pkg::FRAME_W-1:0] r_frame, n_frame;
    logic [wcenv_pkg::FPC_W-1:0]   r_fic, n_fic;
    logic [wcenv_pkg::SUM_W-1:0]   r_sum, n_sum;
    logic [wcenv_pkg::COL_W-1:0]   r_col, n_col;
    logic                          r_done, n_done;

    logic signed [MAG_W-1:0] ext_a, ext_b;
    logic [MAG_W-1:0]        mag_a, mag_b;
    logic [MAG_W:0]          mag;
    logic                    accept, in_win, last, close, fin, add;
    logic [wcenv_pkg::FPC_W-1:0]   fic_inc;
    logic [wcenv_pkg::SUM_W-1:0]   sum_acc;
    logic [wcenv_pkg::CLAMP_W-1:0] col_inc;

    assign o_ready = i_space;
    assign accept  = i_valid && i_space;

    // absolute values, full-scale negative maps to full scale
    assign ext_a = {i_sample_first[SAMPLE_BITS-1], i_sample_first};
    assign ext_b = {i_sample_second[SAMPLE_BITS-1], i_sample_second};
    assign mag_a = ext_a[MAG_W-1] ? MAG_W'(-ext_a) : MAG_W'(ext_a);
    assign mag_b = ext_b[MAG_W-1] ? MAG_W'(-ext_b) : MAG_W'(ext_b);
    assign mag   = {1'b0, mag_a} + ((i_cfg.ch > 2'd1) ? {1'b0, mag_b} : '0);

    // window and column close
    assign in_win  = !r_done && (r_frame >= {1'b0, i_cfg.start}) && (r_frame < i_cfg.endf);
    assign add     = (i_cfg.mode != wcenv_pkg::MODE_QUICK) || (r_fic == '0);
    assign sum_acc = add ? (r_sum + wcenv_pkg::SUM_W'(mag)) : r_sum;
    assign fic_inc = (r_fic < wcenv_pkg::FIC_MAX) ? r_fic + 1'b1 : r_fic;
    assign last    = ({1'b0, r_frame} + 1'b1) >= {1'b0, i_cfg.endf};
    assign close   = in_win && ((fic_inc >= i_cfg.fpc) || last);
    assign col_inc = {4'b0, r_col} + 1'b1;
    assign fin     = last || (col_inc >= i_cfg.cols);

    assign o_push    = accept && close;
    assign o_col.sum = sum_acc;
    assign o_col.num = r_col[wcenv_pkg::OUT_W-1:0];
    assign o_col.fin = fin;

    // advance the counters on every accepted frame
    always_comb begin
        n_frame = r_frame;
        n_fic   = r_fic;
        n_sum   = r_sum;
        n_col   = r_col;
        n_done  = r_done;
        if (accept) begin
            if (r_frame < wcenv_pkg::FRAME_MAX) n_frame = r_frame + 1'b1;
            if (in_win) begin
                if (close) begin
                    n_fic  = '0;
                    n_sum  = '0;
                    n_col  = col_inc[wcenv_pkg::COL_W-1:0];
                    n_done = fin;
                end else begin
                    n_fic = fic_inc;
                    n_sum = sum_acc;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_frame <= '0;
            r_fic   <= '0;
            r_sum   <= '0;
            r_col   <= '0;
            r_done  <= 1'b0;
        end else begin
            r_frame <= n_frame;
            r_fic   <= n_fic;
            r_sum   <= n_sum;
            r_col   <= n_col;
            r_done  <= n_done;
        end
    end

endmodule
`default_nettype wire

FILE: rtl/core/wcenv_queue.sv
// Two-entry queue of closed columns between front and back end.
// Depends on wcenv_pkg.
`default_nettype none
module wcenv_queue (
    input  wire                   i_clk,
    input  wire                   i_rst_n,
    input  wire                   i_push,
    input  wire  wcenv_pkg::t_col i_col,
    input  wire                   i_pop,
    output wcenv_pkg::t_col       o_head,
    output logic [1:0]            o_count
);
    wcenv_pkg::t_col r_mem [2];
    logic r_wp, r_rp;
    logic [1:0] r_cnt;

    assign o_head  = r_mem[r_rp];
    assign o_count = r_cnt;

    // store payload
    always_ff @(posedge i_clk) begin
        if (i_push) r_mem[r_wp] <= i_col;
    end

    // move pointers and count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= '0;
        end else begin
            if (i_push) r_wp <= ~r_wp;
            if (i_pop)  r_rp <= ~r_rp;
            r_cnt <= r_cnt + {1'b0, i_push} - {1'b0, i_pop};
        end
    end

endmodule
`default_nettype wire

FILE: rtl/core/wcenv_back.sv
// Back end: turns a closed column into its height (linear, decibel, quick) with a
// bit-serial divider, a squaring log unit and a reciprocal multiply; holds the output register.
// Depends on wcenv_pkg.
`default_nettype none
module wcenv_back #(
    parameter int SAMPLE_BITS = wcenv_pkg::SAMPLE_BITS
) (
    input  wire                         i_clk,
    input  wire                         i_rst_n,
    input  wire  wcenv_pkg::t_cfg       i_cfg,
    input  wire                         i_q_valid,
    input  wire  wcenv_pkg::t_col       i_q_head,
    output logic                        o_pop,
    output logic                        o_valid,
    input  wire                         i_ready,
    output logic [wcenv_pkg::OUT_W-1:0] o_column_number,
    output logic [wcenv_pkg::OUT_W-1:0] o_column_height,
    output logic                        o_final_column
);
    localparam int DW    = wcenv_pkg::CLAMP_W + SAMPLE_BITS - 1;
    localparam int DEN_W = DW + 1;
    localparam int LV_W  = (DW > wcenv_pkg::SUM_W) ? DW : wcenv_pkg::SUM_W;
    localparam int NUM_W = 48;
    localparam int PR_W  = wcenv_pkg::SUM_W + wcenv_pkg::HALF_W;
    localparam int L_W   = 22;
    localparam int A_W   = 41;
    localparam int DP_W  = wcenv_pkg::FULL_W + wcenv_pkg::HALF_W;

    // divide by the decibel span 45: multiply by ceil(2^24 / 45), keep bits 24 and up
    localparam int          DBQ_IN_W  = 17;
    localparam int          DBQ_SH    = 24;
    localparam int          DBQ_M_W   = 19;
    localparam int          DBQ_P_W   = DBQ_IN_W + DBQ_M_W;
    localparam logic [DBQ_M_W-1:0] DBQ_RECIP = 19'd372828;

    localparam logic [3:0] S_IDLE  = 4'd0;
    localparam logic [3:0] S_QUICK = 4'd1;
    localparam logic [3:0] S_LIN   = 4'd2;
    localparam logic [3:0] S_LNORM = 4'd3;
    localparam logic [3:0] S_LSQ   = 4'd4;
    localparam logic [3:0] S_DBK   = 4'd5;
    localparam logic [3:0] S_DBCMP = 4'd6;
    localparam logic [3:0] S_DIV   = 4'd7;
    localparam logic [3:0] S_DQ    = 4'd8;
    localparam logic [3:0] S_DONE  = 4'd9;
    localparam logic [3:0] S_DBQ   = 4'd10;

    logic [3:0]                    r_state;
    logic [wcenv_pkg::SUM_W-1:0]   r_sum;
    logic [wcenv_pkg::OUT_W-1:0]   r_num_col;
    logic                          r_fin;
    logic [LV_W-1:0]               r_lv;
    logic [5:0]                    r_p;
    logic [30:0]                   r_m;
    logic [15:0]                   r_frac;
    logic [3:0]                    r_step;
    logic                          r_lsel;
    logic [L_W-1:0]                r_ls, r_ld;
    logic [A_W-1:0]                r_a, r_b;
    logic [NUM_W-1:0]              r_num;
    logic [DEN_W-1:0]              r_den;
    logic [DEN_W-1:0]              r_rem;
    logic [5:0]                    r_cnt;
    logic [wcenv_pkg::OUT_W-1:0]   r_res;
    logic                          r_ov;
    logic [wcenv_pkg::OUT_W-1:0]   r_o_num, r_o_h;
    logic                          r_o_fin;

    logic [DW-1:0]      d_val;
    logic [PR_W-1:0]    prod;
    logic [PR_W-1:0]    qshift;
    logic [61:0]        sq;
    logic [31:0]        sq_t;
    logic [15:0]        frac_n;
    logic [DEN_W:0]     rem_sh;
    logic               rem_ge;
    logic [A_W-1:0]     diff;
    logic [DP_W-1:0]    dprod;
    logic [DBQ_P_W-1:0] dquot;
    logic               out_free;
    logic               out_load;

    assign d_val  = DW'({{(wcenv_pkg::CLAMP_W - wcenv_pkg::CH_W){1'b0}}, i_cfg.ch}
                        + {1'b0, i_cfg.fpc}) << (SAMPLE_BITS - 1);
    assign prod   = r_sum * PR_W'(i_cfg.half);
    assign qshift = (i_cfg.ch == 2'd2) ? (prod >> SAMPLE_BITS) : (prod >> (SAMPLE_BITS - 1));
    assign sq     = r_m * r_m;
    assign sq_t   = sq[61:30];
    assign frac_n = {r_frac[14:0], sq_t[31]};
    assign rem_sh = {r_rem, r_num[NUM_W-1]};
    assign rem_ge = rem_sh >= {1'b0, r_den};
    assign diff   = r_a - r_b;
    assign dprod  = diff[wcenv_pkg::FULL_W-1:0] * DP_W'(i_cfg.half);
    assign dquot  = DBQ_P_W'(r_num[DBQ_IN_W-1:0]) * DBQ_P_W'(DBQ_RECIP);

    assign out_free = !r_ov || i_ready;
    assign out_load = (r_state == S_DONE) && out_free;
    assign o_pop    = (r_state == S_IDLE) && i_q_valid;

    assign o_valid         = r_ov;
    assign o_column_number = r_o_num;
    assign o_column_height = r_o_h;
    assign o_final_column  = r_o_fin;

    // sequencer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_ov    <= 1'b0;
        end else begin
            if (out_load) r_ov <= 1'b1;
            else if (i_ready) r_ov <= 1'b0;
            unique case (r_state)
                S_IDLE: begin
                    if (i_q_valid) begin
                        r_sum     <= i_q_head.sum;
                        r_num_col <= i_q_head.num;
                        r_fin     <= i_q_head.fin;
                        r_lv      <= LV_W'(i_q_head.sum);
                        r_p       <= 6'(LV_W - 1);
                        r_lsel    <= 1'b0;
                        case (i_cfg.mode)
                            wcenv_pkg::MODE_QUICK: r_state <= S_QUICK;
                            wcenv_pkg::MODE_DB: begin
                                if (i_q_head.sum == '0) begin
                                    r_res   <= '0;
                                    r_state <= S_DONE;
                                end else begin
                                    r_state <= S_LNORM;
                                end
                            end
                            default: r_state <= S_LIN;
                        endcase
                    end
                end
                S_QUICK: begin
                    r_res   <= (qshift > PR_W'(wcenv_pkg::HEIGHT_MAX)) ? wcenv_pkg::HEIGHT_MAX
                                                                       : qshift[wcenv_pkg::OUT_W-1:0];
                    r_state <= S_DONE;
                end
                S_LIN: begin
                    r_num   <= NUM_W'({prod, 1'b0}) + NUM_W'(d_val);
                    r_den   <= {d_val, 1'b0};
                    r_rem   <= '0;
                    r_cnt   <= '0;
                    r_state <= S_DIV;
                end
                // normalize: shift until the msb is set
                S_LNORM: begin
                    if (r_lv[LV_W-1]) begin
                        r_m     <= r_lv[LV_W-1 -: 31];
                        r_frac  <= '0;
                        r_step  <= '0;
                        r_state <= S_LSQ;
                    end else begin
                        r_lv <= r_lv << 1;
                        r_p  <= r_p - 1'b1;
                    end
                end
                // one fraction bit per squaring
                S_LSQ: begin
                    r_m    <= sq_t[31] ? sq_t[31:1] : sq_t[30:0];
                    r_frac <= frac_n;
                    r_step <= r_step + 1'b1;
                    if (r_step == 4'd15) begin
                        if (!r_lsel) begin
                            r_ls    <= {r_p, frac_n};
                            r_lv    <= LV_W'(d_val);
                            r_p     <= 6'(LV_W - 1);
                            r_lsel  <= 1'b1;
                            r_state <= S_LNORM;
                        end else begin
                            r_ld    <= {r_p, frac_n};
                            r_state <= S_DBK;
                        end
                    end
                end
                S_DBK: begin
                    r_a     <= A_W'(wcenv_pkg::DB_K) * A_W'(r_ls) + A_W'(wcenv_pkg::DB_FULL);
                    r_b     <= A_W'(wcenv_pkg::DB_K) * A_W'(r_ld);
                    r_state <= S_DBCMP;
                end
                S_DBCMP: begin
                    if (r_a <= r_b) begin
                        r_res   <= '0;
                        r_state <= S_DONE;
                    end else if (diff >= A_W'(wcenv_pkg::DB_FULL)) begin
                        r_res   <= wcenv_pkg::OUT_W'(i_cfg.half);
                        r_state <= S_DONE;
                    end else begin
                        r_num   <= NUM_W'(dprod >> 32);
                        r_state <= S_DBQ;
                    end
                end
                // scaled span below 45 * 2^11, quotient fits the height field
                S_DBQ: begin
                    r_res   <= dquot[DBQ_SH +: wcenv_pkg::OUT_W];
                    r_state <= S_DONE;
                end
                // restoring division, one quotient bit per cycle
                S_DIV: begin
                    r_rem <= rem_ge ? DEN_W'(rem_sh - {1'b0, r_den}) : rem_sh[DEN_W-1:0];
                    r_num <= {r_num[NUM_W-2:0], rem_ge};
                    r_cnt <= r_cnt + 1'b1;
                    if (r_cnt == 6'(NUM_W - 1)) r_state <= S_DQ;
                end
                S_DQ: begin
                    r_res   <= (r_num > NUM_W'(wcenv_pkg::HEIGHT_MAX)) ? wcenv_pkg::HEIGHT_MAX
                                                                       : r_num[wcenv_pkg::OUT_W-1:0];
                    r_state <= S_DONE;
                end
                S_DONE: begin
                    if (out_free) begin
                        r_o_num <= r_num_col;
                        r_o_h   <= r_res;
                        r_o_fin <= r_fin;
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

endmodule
`default_nettype wire

FILE: rtl/core/waveform_column_envelope_core.sv
// Waveform column envelope core, top level: configuration registers, front end,
// column queue and back end. Depends on wcenv_pkg, wcenv_front, wcenv_queue, wcenv_back.
//
// Usage:
//   Input channel (i_valid/o_ready) carries one audio frame per word: two signed
//   samples. Frames are counted from reset; only those in [start_frame, end_frame)
//   are grouped into columns. Output channel (o_valid/i_ready) carries one word per
//   closed column: column number, half-height in pixels, final flag.
//   Config channel (i_cfg_valid/o_cfg_ready) writes register i_cfg_index; it is
//   always ready and must only be used while the core is idle.
//   Throughput: the front end takes one frame per cycle as long as the two-entry
//   column queue has room. The back end works on one column at a time: quick
//   mode uses a single multiply and shift, linear mode the 48-step bit-serial
//   divider, decibel mode two log evaluations of up to 34 normalize and 16
//   squaring steps each, then a reciprocal multiply. Short columns therefore
//   throttle input.
//   A stalled receiver holds the output word; the back end finishes the next
//   column and waits, then the queue fills and o_ready drops.
//   Reset (synchronous, active low) restores register defaults and clears the
//   front-end and queue counters; after a final column no words follow until reset.
`default_nettype none
module waveform_column_envelope_core #(
    parameter int SAMPLE_BITS = wcenv_pkg::SAMPLE_BITS
) (
    input  wire                                 i_clk,
    input  wire                                 i_rst_n,
    input  wire                                 i_valid,
    output logic                                o_ready,
    input  wire  signed [SAMPLE_BITS-1:0]       i_sample_first,
    input  wire  signed [SAMPLE_BITS-1:0]       i_sample_second,
    output logic                                o_valid,
    input  wire                                 i_ready,
    output logic [wcenv_pkg::OUT_W-1:0]         o_column_number,
    output logic [wcenv_pkg::OUT_W-1:0]         o_column_height,
    output logic                                o_final_column,
    input  wire                                 i_cfg_valid,
    output logic                                o_cfg_ready,
    input  wire  [wcenv_pkg::CIDX_W-1:0]        i_cfg_index,
    input  wire  [wcenv_pkg::CDAT_W-1:0]        i_cfg_data
);
    logic [wcenv_pkg::CH_W-1:0]    r_ch;
    logic [wcenv_pkg::FPC_W-1:0]   r_fpc;
    logic [wcenv_pkg::HALF_W-1:0]  r_half;
    logic [wcenv_pkg::CCNT_W-1:0]  r_cols;
    logic [wcenv_pkg::MODE_W-1:0]  r_mode;
    logic [wcenv_pkg::START_W-1:0] r_start;
    logic [wcenv_pkg::FRAME_W-1:0] r_end;

    wcenv_pkg::t_cfg cfg;
    wcenv_pkg::t_col push_col, head_col;
    logic            push, pop;
    logic [1:0]      q_cnt;
    logic [wcenv_pkg::CLAMP_W-1:0] cols_ext;

    assign o_cfg_ready = 1'b1;

    // write configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ch    <= 2'd1;
            r_fpc   <= 16'd1;
            r_half  <= 11'd64;
            r_cols  <= 13'd2;
            r_mode  <= wcenv_pkg::MODE_LIN;
            r_start <= '0;
            r_end   <= '0;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                wcenv_pkg::REG_CHANNELS: r_ch    <= i_cfg_data[wcenv_pkg::CH_W-1:0];
                wcenv_pkg::REG_FPC:      r_fpc   <= i_cfg_data[wcenv_pkg::FPC_W-1:0];
                wcenv_pkg::REG_HALF:     r_half  <= i_cfg_data[wcenv_pkg::HALF_W-1:0];
                wcenv_pkg::REG_COLS:     r_cols  <= i_cfg_data[wcenv_pkg::CCNT_W-1:0];
                wcenv_pkg::REG_MODE:     r_mode  <= i_cfg_data[wcenv_pkg::MODE_W-1:0];
                wcenv_pkg::REG_START:    r_start <= i_cfg_data[wcenv_pkg::START_W-1:0];
                wcenv_pkg::REG_END:      r_end   <= i_cfg_data[wcenv_pkg::FRAME_W-1:0];
                default: ;
            endcase
        end
    end

    // clamp out-of-range settings
    assign cols_ext = wcenv_pkg::CLAMP_W'(r_cols);
    always_comb begin
        cfg.ch = (r_ch == '0) ? 2'd1 :
                 (r_ch > 2'(wcenv_pkg::MAX_CHANNELS)) ? 2'(wcenv_pkg::MAX_CHANNELS) : r_ch;
        cfg.fpc = (r_fpc == '0) ? 16'd1 : r_fpc;
        cfg.half = r_half;
        cfg.cols = (cols_ext < 17'd2) ? 17'd2 :
                   (cols_ext > wcenv_pkg::CLAMP_W'(wcenv_pkg::MAX_COLUMNS))
                       ? wcenv_pkg::CLAMP_W'(wcenv_pkg::MAX_COLUMNS) : cols_ext;
        cfg.mode = (r_mode == wcenv_pkg::MODE_RSV) ? wcenv_pkg::MODE_LIN : r_mode;
        cfg.start = r_start;
        cfg.endf = r_end;
    end

    wcenv_front #(.SAMPLE_BITS(SAMPLE_BITS)) u_front (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_valid         (i_valid),
        .o_ready         (o_ready),
        .i_sample_first  (i_sample_first),
        .i_sample_second (i_sample_second),
        .i_cfg           (cfg),
        .i_space         (q_cnt != 2'd2),
        .o_push          (push),
        .o_col           (push_col)
    );

    wcenv_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_col   (push_col),
        .i_pop   (pop),
        .o_head  (head_col),
        .o_count (q_cnt)
    );

    wcenv_back #(.SAMPLE_BITS(SAMPLE_BITS)) u_back (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg           (cfg),
        .i_q_valid       (q_cnt != 2'd0),
        .i_q_head        (head_col),
        .o_pop           (pop),
        .o_valid         (o_valid),
        .i_ready         (i_ready),
        .o_column_number (o_column_number),
        .o_column_height (o_column_height),
        .o_final_column  (o_final_column)
    );

    // queue never overflows or underflows
    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        push |-> (q_cnt != 2'd2))
        else $error("column queue overflow");

    a_no_underflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        pop |-> (q_cnt != 2'd0))
        else $error("column queue underflow");

    // a push into a full-minus-one queue with no pop leaves the front stalled
    a_full_stalls: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (push && !pop && q_cnt == 2'd1) |=> !o_ready)
        else $error("front not stalled on full queue");

endmodule
`default_nettype wire

FILE: verif/tb_waveform_column_envelope_core.sv
// Self-checking testbench for waveform_column_envelope_core: frames in, column heights out.
// Depends on wcenv_pkg and the core RTL; a built-in column predictor checks every word.
`default_nettype none
module tb_waveform_column_envelope_core;
    timeunit 1ns;
    timeprecision 1ps;
    import wcenv_pkg::*;

    typedef struct {
        logic [OUT_W-1:0] num;
        logic [OUT_W-1:0] height;
        logic             fin;
    } col_word_t;

    typedef enum logic { ROW_CFG, ROW_FRM } row_kind_t;

    typedef struct {
        row_kind_t         kind;
        logic [CIDX_W-1:0] idx;
        logic [CDAT_W-1:0] data;
        logic [15:0]       s1;
        logic [15:0]       s2;
        bit                typed;
        col_word_t         want;
    } stim_row_t;

    localparam int SETTLE_CYCLES = 200;

    logic                     i_clk = 1'b0;
    logic                     i_rst_n = 1'b0;
    logic                     i_valid = 1'b0;
    logic                     o_ready;
    logic signed [15:0]       i_sample_first = '0;
    logic signed [15:0]       i_sample_second = '0;
    logic                     o_valid;
    logic                     i_ready = 1'b0;
    logic [OUT_W-1:0]         o_column_number;
    logic [OUT_W-1:0]         o_column_height;
    logic                     o_final_column;
    logic                     i_cfg_valid = 1'b0;
    logic                     o_cfg_ready;
    logic [CIDX_W-1:0]        i_cfg_index = '0;
    logic [CDAT_W-1:0]        i_cfg_data = '0;

    waveform_column_envelope_core i_dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_valid(i_valid), .o_ready(o_ready),
        .i_sample_first(i_sample_first), .i_sample_second(i_sample_second),
        .o_valid(o_valid), .i_ready(i_ready),
        .o_column_number(o_column_number), .o_column_height(o_column_height),
        .o_final_column(o_final_column),
        .i_cfg_valid(i_cfg_valid), .o_cfg_ready(o_cfg_ready),
        .i_cfg_index(i_cfg_index), .i_cfg_data(i_cfg_data)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // predictor copy of registers and column state
    logic [1:0]   cfg_ch;
    logic [15:0]  cfg_fpc;
    logic [10:0]  cfg_half;
    logic [12:0]  cfg_cols;
    logic [1:0]   cfg_mode;
    logic [23:0]  cfg_start;
    logic [24:0]  cfg_end;
    logic [24:0]  frame_count;
    logic [15:0]  column_fill;
    logic [33:0]  level_sum;
    logic [12:0]  next_column;
    bit           window_closed;

    col_word_t pending_columns[$];
    int        mismatches = 0;
    int        columns_seen = 0;
    int        frames_sent = 0;
    bit        steady = 1'b0;

    task automatic report(string what, int want, int got);
        $display("%0t mismatch: %s expected %0d got %0d", $realtime, what, want, got);
        mismatches++;
    endtask

    function automatic logic [16:0] magnitude(logic [15:0] raw);
        return raw[15] ? 17'h10000 - raw : {1'b0, raw};
    endfunction

    // log2 in Q16: msb position, then 16 squaring steps on a Q30 mantissa
    function automatic longint unsigned log2_q16(longint unsigned v);
        int p;
        longint unsigned m, fr;
        p = 0;
        fr = 0;
        while (p < 63 && (v >> (p + 1)) != 0) p++;
        m = (p >= 30) ? (v >> (p - 30)) : (v << (30 - p));
        for (int i = 0; i < 16; i++) begin
            m = (m * m) >> 30;
            fr = fr << 1;
            if (m >= (64'd2 << 30)) begin
                fr = fr | 1;
                m = m >> 1;
            end
        end
        return (longint'(p) << 16) | fr;
    endfunction

    function automatic logic [OUT_W-1:0] column_height_of(int ch, int f, logic [1:0] mode);
        longint unsigned s, h, d, r, a, b, full;
        s = level_sum;
        h = cfg_half;
        d = longint'(ch + f) << 15;
        full = longint'(45) << 32;
        if (mode == MODE_QUICK) begin
            r = (s * h) / (longint'(ch) << 15);
        end else if (mode == MODE_DB) begin
            if (s == 0) return '0;
            a = 64'd197283 * log2_q16(s) + full;
            b = 64'd197283 * log2_q16(d);
            if (a <= b) return '0;
            r = (a - b >= full) ? h : ((a - b) * h) / full;
        end else begin
            r = (2 * s * h + d) / (2 * d);
        end
        return (r > 4095) ? HEIGHT_MAX : r[OUT_W-1:0];
    endfunction

    // advance predictor by one frame; returns 1 when a column closes
    function automatic bit predict_frame(logic [15:0] s1, logic [15:0] s2,
                                         output col_word_t word);
        logic [24:0] idx;
        int ch, f, cols;
        logic [1:0] mode;
        logic [17:0] mag;
        bit last, fin;
        idx = frame_count;
        word = '{default: '0};
        if (frame_count != FRAME_MAX) frame_count++;
        if (window_closed || idx < cfg_start || idx >= cfg_end) return 0;
        ch = (cfg_ch == 0) ? 1 : ((cfg_ch > 2) ? 2 : cfg_ch);
        f = (cfg_fpc == 0) ? 1 : cfg_fpc;
        cols = (cfg_cols < 2) ? 2 : ((cfg_cols > 4096) ? 4096 : cfg_cols);
        mode = (cfg_mode == MODE_RSV) ? MODE_LIN : cfg_mode;
        mag = magnitude(s1);
        if (ch > 1) mag += magnitude(s2);
        if (mode != MODE_QUICK || column_fill == 0) level_sum = level_sum + mag;
        if (column_fill != FIC_MAX) column_fill++;
        last = (26'(idx) + 1) >= cfg_end;
        if (column_fill < f && !last) return 0;
        fin = last || (32'(next_column) + 1 >= cols);
        word.num = next_column[OUT_W-1:0];
        word.height = column_height_of(ch, f, mode);
        word.fin = fin;
        next_column++;
        column_fill = '0;
        level_sum = '0;
        if (fin) window_closed = 1'b1;
        return 1;
    endfunction

    // compare each output word with the oldest expectation
    always @(posedge i_clk) begin
        col_word_t want;
        if (i_rst_n && o_valid && i_ready) begin
            columns_seen++;
            if (pending_columns.size() == 0) begin
                report("unexpected column", -1, o_column_number);
            end else begin
                want = pending_columns.pop_front();
                if (o_column_number !== want.num) report("column_number", want.num, o_column_number);
                if (o_column_height !== want.height) report("column_height", want.height, o_column_height);
                if (o_final_column !== want.fin) report("final_column", want.fin, o_final_column);
            end
        end
    end

    // receiver stalls
    always @(posedge i_clk) begin
        i_ready <= steady ? 1'b1 : ($urandom_range(99) >= 35);
    end

    // hold one frame until accepted, then record its expectation
    task automatic send_frame(logic [15:0] s1, logic [15:0] s2, bit typed, col_word_t typed_word);
        col_word_t word;
        i_valid <= 1'b1;
        i_sample_first <= s1;
        i_sample_second <= s2;
        do @(posedge i_clk); while (!o_ready);
        frames_sent++;
        if (predict_frame(s1, s2, word)) pending_columns.push_back(typed ? typed_word : word);
    endtask

    // idle the sender for a random gap
    task automatic sender_gap();
        if (!steady && $urandom_range(99) < 35) begin
            i_valid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge i_clk);
        end
    endtask

    // drop valid, drain all expected words, then let the back end finish
    task automatic settle();
        i_valid <= 1'b0;
        @(posedge i_clk);
        while (pending_columns.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_reg(logic [CIDX_W-1:0] idx, logic [CDAT_W-1:0] data);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= data;
        do @(posedge i_clk); while (!o_cfg_ready);
        case (idx)
            REG_CHANNELS: cfg_ch = data[1:0];
            REG_FPC:      cfg_fpc = data[15:0];
            REG_HALF:     cfg_half = data[10:0];
            REG_COLS:     cfg_cols = data[12:0];
            REG_MODE:     cfg_mode = data[1:0];
            REG_START:    cfg_start = data[23:0];
            REG_END:      cfg_end = data[24:0];
            default: ;
        endcase
    endtask

    function automatic logic [15:0] pick_sample();
        case ($urandom_range(9))
            0: return 16'h8000;
            1: return 16'h7FFF;
            2: return 16'h0000;
            3: return 16'hFFFF;
            default: return 16'($urandom);
        endcase
    endfunction

    function automatic logic [15:0] pick_fpc();
        int r;
        r = $urandom_range(99);
        if (r < 5) return 16'd0;
        if (r < 9) return 16'hFFFF;
        if (r < 20) return 16'($urandom_range(9, 64));
        return 16'($urandom_range(1, 6));
    endfunction

    stim_row_t script[$];

    function automatic void add_cfg(logic [CIDX_W-1:0] idx, logic [CDAT_W-1:0] data);
        script.push_back('{ROW_CFG, idx, data, 16'h0, 16'h0, 1'b0, '{default: '0}});
    endfunction

    function automatic void add_frm(logic [15:0] s1, logic [15:0] s2);
        script.push_back('{ROW_FRM, '0, '0, s1, s2, 1'b0, '{default: '0}});
    endfunction

    function automatic void add_chk(logic [15:0] s1, logic [OUT_W-1:0] num, logic [OUT_W-1:0] h);
        script.push_back('{ROW_FRM, '0, '0, s1, 16'h0, 1'b1, '{num, h, 1'b0}});
    endfunction

    initial begin
        #30ms;
        $display("timeout with %0d columns outstanding", pending_columns.size());
        $display("** waveform_column_envelope_core: FAILED **");
        $finish;
    end

    initial begin
        col_word_t none_word;
        bit prev_cfg;
        int phase_len;
        none_word = '{default: '0};
        cfg_ch = 2'd1; cfg_fpc = 16'd1; cfg_half = 11'd64; cfg_cols = 13'd2;
        cfg_mode = MODE_LIN; cfg_start = '0; cfg_end = '0;
        frame_count = '0; column_fill = '0; level_sum = '0; next_column = '0;
        window_closed = 1'b0;

        // directed: empty window after reset, extremes, each mode, out-of-range codes
        add_frm(16'd100, 16'hFFFB);
        add_frm(16'd0, 16'd0);
        add_cfg(REG_COLS, 25'd4096);
        add_cfg(REG_END, 25'd16777216);
        add_chk(16'h7FFF, 12'd0, 12'd32);
        add_chk(16'h8000, 12'd1, 12'd32);
        add_chk(16'h0000, 12'd2, 12'd0);
        add_cfg(REG_CHANNELS, 25'd2);
        add_cfg(REG_FPC, 25'd2);
        add_frm(16'h7FFF, 16'h8000);
        add_frm(16'hFFFF, 16'h0001);
        add_cfg(REG_MODE, CDAT_W'(MODE_DB));
        add_frm(16'h0, 16'h0);
        add_frm(16'h0, 16'h0);
        add_frm(16'h8000, 16'h8000);
        add_frm(16'h7FFF, 16'h7FFF);
        add_cfg(REG_HALF, 25'd2047);
        add_frm(16'h1, 16'h0);
        add_frm(16'h1, 16'h0);
        add_cfg(REG_MODE, CDAT_W'(MODE_QUICK));
        add_cfg(REG_FPC, 25'd3);
        add_frm(16'h8000, 16'h8000);
        add_frm(16'h5, 16'h5);
        add_frm(16'h7, 16'h7);
        add_cfg(REG_MODE, CDAT_W'(MODE_RSV));
        add_cfg(REG_CHANNELS, 25'd0);
        add_cfg(REG_FPC, 25'd0);
        add_cfg(REG_HALF, 25'd0);
        add_frm(16'h7FFF, 16'h1);
        add_frm(16'h8000, 16'h1);
        add_cfg(REG_CHANNELS, 25'd3);
        add_cfg(REG_HALF, 25'd1);
        add_cfg(REG_FPC, 25'd65535);
        add_frm(16'h1234, 16'h8000);
        add_frm(16'h8000, 16'h7FFF);
        add_frm(16'hABCD, 16'h5555);
        add_cfg(REG_FPC, 25'd1);
        add_frm(16'd123, 16'hFE38);

        // reset, held low, then released
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // walk the directed table
        prev_cfg = 1'b0;
        foreach (script[k]) begin
            if (script[k].kind == ROW_CFG) begin
                if (!prev_cfg) settle();
                write_reg(script[k].idx, script[k].data);
                prev_cfg = 1'b1;
            end else begin
                if (prev_cfg) i_cfg_valid <= 1'b0;
                send_frame(script[k].s1, script[k].s2, script[k].typed, script[k].want);
                sender_gap();
                prev_cfg = 1'b0;
            end
        end

        // random phases; each starts idle with fresh settings
        for (int p = 0; p < 14; p++) begin
            settle();
            if (p == 7) begin
                // window start pushed out of reach: frames only advance the counter
                write_reg(REG_START, 25'd16777215);
                i_cfg_valid <= 1'b0;
                repeat (40) begin
                    send_frame(pick_sample(), pick_sample(), 1'b0, none_word);
                    sender_gap();
                end
                settle();
                write_reg(REG_START, 25'd0);
            end
            steady = (p == 4);
            write_reg(REG_CHANNELS, CDAT_W'($urandom_range(3)));
            write_reg(REG_FPC, CDAT_W'(pick_fpc()));
            write_reg(REG_HALF, CDAT_W'(($urandom_range(3) == 0)
                                        ? (($urandom_range(1)) ? 2047 : 0)
                                        : $urandom_range(2047)));
            write_reg(REG_MODE, CDAT_W'($urandom_range(3)));
            case ($urandom_range(2))
                0: write_reg(REG_COLS, 25'd4096);
                1: write_reg(REG_COLS, 25'd8191);
                default: write_reg(REG_COLS, 25'd2500);
            endcase
            if (p == 13) begin
                // last phase closes the window early at its end frame
                write_reg(REG_FPC, 25'd4);
                write_reg(REG_END, frame_count + 25'd10);
            end
            i_cfg_valid <= 1'b0;
            phase_len = (p == 13) ? 20 : 101;
            repeat (phase_len) begin
                send_frame(pick_sample(), pick_sample(), 1'b0, none_word);
                sender_gap();
            end
        end
        steady = 1'b0;
        settle();

        $display("covered %0d frames and %0d columns over 14 random phases", frames_sent,
                 columns_seen);
        $display("modes linear, decibel, quick and reserved; window start, end and final column");
        if (mismatches == 0 && pending_columns.size() == 0) begin
            $display("** waveform_column_envelope_core: PASSED **");
        end else begin
            $display("** waveform_column_envelope_core: FAILED **");
        end
        $finish;
    end

endmodule
`default_nettype wire
